FILE: hw/rtl/jsu_pkg.sv
package jsu_pkg;

    // ascii codes used by the decoder
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // utf-8 encoding constants
    localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
    localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
    localparam logic [7:0]  UTF8_CONT     = 8'h80;
    localparam logic [7:0]  MASK_LEAD2    = 8'h1F;
    localparam logic [7:0]  MASK_LEAD3    = 8'h0F;
    localparam logic [7:0]  MASK_CONT     = 8'h3F;
    localparam logic [7:0]  MASK_ASCII    = 8'h7F;

    // status codes on a report beat
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_NOOPEN  = 3'd2;
    localparam logic [2:0] ST_BADESC  = 3'd3;
    localparam logic [2:0] ST_BADUNI  = 3'd4;
    localparam logic [2:0] ST_NOCLOSE = 3'd5;
    localparam logic [2:0] ST_SPARE   = 3'd6;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int MAX_RES    = 4;

    // results of one input byte: data bytes first, then an optional status
    typedef struct packed {
        logic [1:0]      data_count;
        logic [2:0][7:0] data;
        logic            has_status;
        logic [2:0]      status;
    } dec_t;

    // one queued result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic [2:0] status;
        logic       last;
    } result_t;

    // hex digit value, msb set when the byte is a valid digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            v = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            v = {1'b1, 4'(c - 8'h37)};
        return v;
    endfunction

endpackage

FILE: hw/rtl/jsu_decode.sv
module jsu_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    text_byte,
    input  logic          end_of_text,
    output jsu_pkg::dec_t dec
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_TAIL,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_point_reg, code_point_next;

    logic [4:0]  hv;
    logic [15:0] cp_shift;
    logic [2:0]  end_code;

    // decode the byte in the input register
    always_comb
    begin
        hv              = hex_value(text_byte);
        cp_shift        = {code_point_reg[11:0], hv[3:0]};
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        code_point_next = code_point_reg;
        dec             = '0;
        end_code        = ST_NONE;

        if (text_byte != 8'd0)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (text_byte == CH_QUOTE)
                        phase_next = PH_BODY;
                    else if (text_byte > CH_SPACE)
                    begin
                        dec.has_status = 1'b1;
                        dec.status     = ST_NOOPEN;
                        phase_next     = PH_SKIP;
                    end
                end
                PH_BODY:
                begin
                    if (text_byte == CH_QUOTE)
                        phase_next = PH_TAIL;
                    else if (text_byte == CH_BSLASH)
                        phase_next = PH_ESC;
                    else
                    begin
                        dec.data[0]    = text_byte;
                        dec.data_count = 2'd1;
                    end
                end
                PH_ESC:
                begin
                    phase_next     = PH_BODY;
                    dec.data_count = 2'd1;
                    unique case (text_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: dec.data[0] = text_byte;
                        CH_LC_B: dec.data[0] = CH_BS;
                        CH_LC_F: dec.data[0] = CH_FF;
                        CH_LC_N: dec.data[0] = CH_LF;
                        CH_LC_R: dec.data[0] = CH_CR;
                        CH_LC_T: dec.data[0] = CH_TAB;
                        CH_LC_U:
                        begin
                            dec.data_count  = 2'd0;
                            phase_next      = PH_HEX;
                            hex_count_next  = 2'd0;
                            code_point_next = 16'd0;
                        end
                        default:
                        begin
                            dec.data_count = 2'd0;
                            dec.has_status = 1'b1;
                            dec.status     = ST_BADESC;
                            phase_next     = PH_SKIP;
                        end
                    endcase
                end
                PH_HEX:
                begin
                    if (!hv[4])
                    begin
                        dec.has_status = 1'b1;
                        dec.status     = ST_BADUNI;
                        phase_next     = PH_SKIP;
                    end
                    else
                    begin
                        code_point_next = cp_shift;
                        if (hex_count_reg == 2'd3)
                        begin
                            hex_count_next = 2'd0;
                            phase_next     = PH_BODY;
                            // utf-8 encode the finished code point
                            if (cp_shift < CP_TWO_BYTE)
                            begin
                                dec.data[0]    = cp_shift[7:0] & MASK_ASCII;
                                dec.data_count = 2'd1;
                            end
                            else if (cp_shift < CP_THREE_BYTE)
                            begin
                                dec.data[0]    = (cp_shift[13:6] & MASK_LEAD2) | UTF8_LEAD2;
                                dec.data[1]    = (cp_shift[7:0] & MASK_CONT) | UTF8_CONT;
                                dec.data_count = 2'd2;
                            end
                            else
                            begin
                                dec.data[0]    = (cp_shift[15:8] >> 4) | UTF8_LEAD3;
                                dec.data[1]    = (cp_shift[13:6] & MASK_CONT) | UTF8_CONT;
                                dec.data[2]    = (cp_shift[7:0] & MASK_CONT) | UTF8_CONT;
                                dec.data_count = 2'd3;
                            end
                        end
                        else
                            hex_count_next = hex_count_reg + 2'd1;
                    end
                end
                PH_TAIL:
                begin
                    if (text_byte > CH_SPACE)
                    begin
                        dec.has_status = 1'b1;
                        dec.status     = ST_SPARE;
                        phase_next     = PH_SKIP;
                    end
                end
                default: ;
            endcase
        end

        // end of text: report by phase, then rearm on end_of_text
        if (text_byte == 8'd0 || end_of_text)
        begin
            unique case (phase_next)
                PH_LEAD: end_code = ST_NOOPEN;
                PH_BODY: end_code = ST_NOCLOSE;
                PH_ESC:  end_code = ST_BADESC;
                PH_HEX:  end_code = ST_BADUNI;
                PH_TAIL: end_code = ST_OK;
                default: end_code = ST_NONE;
            endcase
            if (end_code != ST_NONE)
            begin
                dec.has_status = 1'b1;
                dec.status     = end_code;
                phase_next     = PH_SKIP;
            end
            if (end_of_text)
            begin
                phase_next      = PH_LEAD;
                hex_count_next  = 2'd0;
                code_point_next = 16'd0;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            hex_count_reg  <= 2'd0;
            code_point_reg <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            code_point_reg <= code_point_next;
        end
    end

    // end of text always rearms the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && end_of_text) |=> (phase_reg == PH_LEAD && hex_count_reg == 2'd0))
        else $error("parser did not rearm after end of text");

    // three data bytes only come from a finished unicode escape
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && dec.data_count == 2'd3) |-> (phase_reg == PH_HEX && hex_count_reg == 2'd3))
        else $error("three-byte output outside a unicode escape");

endmodule

FILE: hw/rtl/jsu_fifo.sv
module jsu_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jsu_pkg::dec_t    dec,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output jsu_pkg::result_t out_head
);
    import jsu_pkg::*;

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic [2:0]         push_n;
    logic               pop;
    result_t            entry [MAX_RES];

    // expand the decoded results into queue beats
    always_comb
    begin
        push_n = push ? (3'(dec.data_count) + 3'(dec.has_status)) : 3'd0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            entry[i] = '0;
            if (i < 3 && 2'(i) < dec.data_count)
            begin
                entry[i].out_byte = dec.data[i[1:0]];
                entry[i].is_data  = 1'b1;
            end
            else
                entry[i].status = dec.status;
            entry[i].last = (3'(i) == push_n - 3'd1);
        end
    end

    assign pop         = out_valid && out_ready;
    assign out_valid   = (count_reg != '0);
    assign out_head    = mem_reg[rd_ptr_reg];
    assign room        = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES));
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, up to four writes a cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (3'(i) < push_n)
                mem_reg[wr_ptr_reg + FIFO_AW'(i)] <= entry[i];
        end
    end

    // never overfilled
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    // pushes only land while there is room for a full set of results
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 3'd0) |-> room)
        else $error("push without room");

endmodule

FILE: hw/rtl/json_string_unescape_utf8.sv
// Decodes one JSON string literal per text, one input byte per beat. Each byte
// is held in an input register, decoded combinationally into up to four
// result beats (three UTF-8 bytes and one status) and written into an
// eight-entry result queue that drives the output. Input is taken every cycle
// while the queue holds four results or fewer; the output drains one result per
// cycle while m_tready is high, so a \uXXXX escape (six input bytes, at most
// four results) keeps a sustained rate of one input byte per cycle, and each
// result passes through the input register and the queue. A status beat (tuser
// low) ends each text; tlast marks the last result caused by one input byte.
module json_string_unescape_utf8 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, rest zero
    output logic        m_tuser,   // is_data
    output logic        m_tlast    // last
);
    import jsu_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;
    logic       room;
    logic       adv;
    dec_t       dec;
    result_t    head;

    assign adv      = in_valid_reg && room;
    assign s_tready = !in_valid_reg || adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    jsu_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (adv),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .dec         (dec)
    );

    jsu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (adv),
        .dec       (dec),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_head  (head)
    );

    // output beat
    assign m_tdata = {5'd0, head.status, head.out_byte};
    assign m_tuser = head.is_data;
    assign m_tlast = head.last;

endmodule

FILE: test/tb_json_string_unescape_utf8.sv
module tb_json_string_unescape_utf8;

    import jsu_pkg::*;

    // decoder phases of the predictor
    typedef enum logic [2:0] {
        SCAN_LEAD = 3'd0,
        SCAN_BODY = 3'd1,
        SCAN_ESC  = 3'd2,
        SCAN_HEX  = 3'd3,
        SCAN_TAIL = 3'd4,
        SCAN_SKIP = 3'd5
    } scan_phase_t;

    // one directed stimulus row, with an optional typed-in result
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam int N_DIRECTED  = 26;
    localparam int LIVE_TARGET = 360;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] text_byte
    logic        s_tlast;    // end_of_text
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [7:0] out_byte, [10:8] status, rest zero
    logic        m_tuser;    // is_data
    logic        m_tlast;    // last

    // side info that travels with each input beat
    logic        beat_typed;
    result_t     beat_want;

    logic        idle_en;
    int          mismatches;
    int          live_beats;

    // predictor state
    scan_phase_t scan_phase;
    logic [1:0]  hex_taken;
    logic [15:0] code_acc;
    result_t     decoded_expect [$];

    stim_row_t   directed_rows [N_DIRECTED];
    logic [7:0]  escape_chars [8];

    json_string_unescape_utf8 u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic result_t data_beat(logic [7:0] b);
        return '{out_byte: b, is_data: 1'b1, status: ST_NONE, last: 1'b0};
    endfunction

    function automatic result_t status_beat(logic [2:0] code);
        return '{out_byte: 8'h00, is_data: 1'b0, status: code, last: 1'b0};
    endfunction

    // final report of a text, then drop bytes until end of text
    function automatic void close_text(logic [2:0] code);
        scan_phase = SCAN_SKIP;
        decoded_expect.push_back(status_beat(code));
    endfunction

    // decode one text byte, queue the beats it causes, return their count
    function automatic int decode_text_beat(logic [7:0] b, logic eot);
        int         first;
        logic       digit_ok;
        logic [3:0] nib;
        logic [2:0] end_code;
        result_t    tail;
        first    = decoded_expect.size();
        digit_ok = 1'b0;
        nib      = 4'd0;
        end_code = ST_NONE;
        if (b != 8'h00) begin
            case (scan_phase)
                SCAN_LEAD: begin
                    if (b == CH_QUOTE)
                        scan_phase = SCAN_BODY;
                    else if (b > CH_SPACE)
                        close_text(ST_NOOPEN);
                end
                SCAN_BODY: begin
                    if (b == CH_QUOTE)
                        scan_phase = SCAN_TAIL;
                    else if (b == CH_BSLASH)
                        scan_phase = SCAN_ESC;
                    else
                        decoded_expect.push_back(data_beat(b));
                end
                SCAN_ESC: begin
                    scan_phase = SCAN_BODY;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: decoded_expect.push_back(data_beat(b));
                        CH_LC_B: decoded_expect.push_back(data_beat(CH_BS));
                        CH_LC_F: decoded_expect.push_back(data_beat(CH_FF));
                        CH_LC_N: decoded_expect.push_back(data_beat(CH_LF));
                        CH_LC_R: decoded_expect.push_back(data_beat(CH_CR));
                        CH_LC_T: decoded_expect.push_back(data_beat(CH_TAB));
                        CH_LC_U:
                        begin
                            scan_phase = SCAN_HEX;
                            hex_taken  = 2'd0;
                            code_acc   = 16'h0000;
                        end
                        default: close_text(ST_BADESC);
                    endcase
                end
                SCAN_HEX: begin
                    // digits in either case
                    if (b >= 8'h30 && b <= 8'h39) begin
                        digit_ok = 1'b1;
                        nib      = 4'(b - 8'h30);
                    end else if (b >= 8'h61 && b <= 8'h66) begin
                        digit_ok = 1'b1;
                        nib      = 4'(b - 8'h61 + 8'd10);
                    end else if (b >= 8'h41 && b <= 8'h46) begin
                        digit_ok = 1'b1;
                        nib      = 4'(b - 8'h41 + 8'd10);
                    end
                    if (!digit_ok) begin
                        close_text(ST_BADUNI);
                    end else begin
                        code_acc = {code_acc[11:0], nib};
                        if (hex_taken == 2'd3) begin
                            hex_taken  = 2'd0;
                            scan_phase = SCAN_BODY;
                            // utf-8 encoding of the code point
                            if (code_acc < CP_TWO_BYTE) begin
                                decoded_expect.push_back(data_beat(code_acc[7:0] & MASK_ASCII));
                            end else if (code_acc < CP_THREE_BYTE) begin
                                decoded_expect.push_back(
                                    data_beat(UTF8_LEAD2 | {3'b000, code_acc[10:6]}));
                                decoded_expect.push_back(
                                    data_beat(UTF8_CONT | {2'b00, code_acc[5:0]}));
                            end else begin
                                decoded_expect.push_back(
                                    data_beat(UTF8_LEAD3 | {4'h0, code_acc[15:12]}));
                                decoded_expect.push_back(
                                    data_beat(UTF8_CONT | {2'b00, code_acc[11:6]}));
                                decoded_expect.push_back(
                                    data_beat(UTF8_CONT | {2'b00, code_acc[5:0]}));
                            end
                        end else begin
                            hex_taken = hex_taken + 2'd1;
                        end
                    end
                end
                SCAN_TAIL: begin
                    if (b > CH_SPACE)
                        close_text(ST_SPARE);
                end
                default: ;
            endcase
        end
        // end of text, status depends on where it stopped
        if (b == 8'h00 || eot) begin
            case (scan_phase)
                SCAN_LEAD: end_code = ST_NOOPEN;
                SCAN_BODY: end_code = ST_NOCLOSE;
                SCAN_ESC:  end_code = ST_BADESC;
                SCAN_HEX:  end_code = ST_BADUNI;
                SCAN_TAIL: end_code = ST_OK;
                default:   end_code = ST_NONE;
            endcase
            if (end_code != ST_NONE)
                close_text(end_code);
            if (eot) begin
                scan_phase = SCAN_LEAD;
                hex_taken  = 2'd0;
                code_acc   = 16'h0000;
            end
        end
        // mark the last beat of this input
        if (decoded_expect.size() > first) begin
            tail      = decoded_expect.pop_back();
            tail.last = 1'b1;
            decoded_expect.push_back(tail);
        end
        return decoded_expect.size() - first;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", field, $time, got, want);
        mismatches++;
    endtask

    // drive one input beat and wait until it is taken
    task automatic send_beat(input logic [7:0] b, input logic eot, input logic typed,
                             input result_t want);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tlast    <= eot;
        beat_typed <= typed;
        beat_want  <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // one random text: well formed, broken in one of several ways, or pure noise
    task automatic send_random_text();
        logic [7:0]  text [$];
        logic [7:0]  fault [$];
        logic [7:0]  raw;
        logic [15:0] cp;
        logic [3:0]  nib;
        int          shape;
        int          pos;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(1, 8))
                text.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2))
                text.push_back(8'($urandom_range(1, 32)));
            text.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 3))
                    0, 1: begin
                        do
                            raw = 8'($urandom_range(1, 255));
                        while (raw == CH_QUOTE || raw == CH_BSLASH);
                        text.push_back(raw);
                    end
                    2: begin
                        text.push_back(CH_BSLASH);
                        text.push_back(escape_chars[$urandom_range(0, 7)]);
                    end
                    default: begin
                        // code point from each utf-8 length, edges and surrogates
                        case ($urandom_range(0, 5))
                            0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                            2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                            3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                            4: cp = ($urandom_range(0, 1)) ? 16'h007F : 16'h0080;
                            default: cp = ($urandom_range(0, 1)) ? 16'h07FF : 16'hFFFF;
                        endcase
                        text.push_back(CH_BSLASH);
                        text.push_back(CH_LC_U);
                        for (int i = 3; i >= 0; i--) begin
                            nib = cp[i*4 +: 4];
                            if (nib < 4'd10)
                                text.push_back(8'(8'h30 + nib));
                            else
                                text.push_back(8'((($urandom_range(0, 1)) ? 8'h41 : 8'h61)
                                                   + nib - 8'd10));
                        end
                    end
                endcase
            end
            text.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 2))
                text.push_back(8'($urandom_range(1, 32)));
            case (shape)
                1: text = text[0:$urandom_range(0, text.size() - 1)];
                2: begin
                    // bad escape or bad hex digit somewhere in the text
                    if ($urandom_range(0, 1)) begin
                        fault.push_back(CH_BSLASH);
                        fault.push_back(($urandom_range(0, 1)) ? 8'h78 : 8'h55);
                    end else begin
                        fault.push_back(CH_BSLASH);
                        fault.push_back(CH_LC_U);
                        repeat ($urandom_range(0, 3))
                            fault.push_back(8'h30);
                        fault.push_back(8'h67);
                    end
                    pos = $urandom_range(1, text.size() - 1);
                    foreach (fault[i])
                        text.insert(pos + i, fault[i]);
                end
                3: text.push_back(8'($urandom_range(33, 255)));
                4: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
                5: begin
                    // zero terminator, then junk up to end of text
                    text.push_back(8'h00);
                    repeat ($urandom_range(0, 3))
                        text.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
        end
        foreach (text[i])
            send_beat(text[i], i == text.size() - 1, 1'b0, '0);
    endtask

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver with random stall bursts
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // predict on each input beat, check each output beat
    always @(posedge clk) begin : check_beats
        result_t want;
        int      n;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                live_beats++;
                n = decode_text_beat(s_tdata, s_tlast);
                // a typed row gives a single beat that replaces the prediction
                if (beat_typed) begin
                    repeat (n) void'(decoded_expect.pop_back());
                    want      = beat_want;
                    want.last = 1'b1;
                    decoded_expect.push_back(want);
                end
            end
            if (m_tvalid && m_tready) begin
                if (decoded_expect.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, 0);
                end else begin
                    want = decoded_expect.pop_front();
                    if (m_tdata[7:0] != want.out_byte)
                        report_mismatch("out_byte", m_tdata[7:0], want.out_byte);
                    if (m_tdata[10:8] != want.status)
                        report_mismatch("status", m_tdata[10:8], want.status);
                    if (m_tdata[15:11] != 5'd0)
                        report_mismatch("tdata pad", m_tdata[15:11], 0);
                    if (m_tuser != want.is_data)
                        report_mismatch("is_data", m_tuser, want.is_data);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
        end
    end

    // overall time limit
    initial begin
        #(12 * 400000);
        $display("status: fail");
        $finish;
    end

    // main sequence
    initial begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        beat_typed = 1'b0;
        beat_want  = '0;
        idle_en    = 1'b1;
        mismatches = 0;
        live_beats = 0;
        scan_phase = SCAN_LEAD;
        hex_taken  = 2'd0;
        code_acc   = 16'h0000;

        escape_chars = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B,
                         CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};

        directed_rows = '{
            // ok text: whitespace, raw extremes, escapes, \u0000, \uFFFF
            '{CH_SPACE,  1'b0, 1'b0, '0},
            '{CH_QUOTE,  1'b0, 1'b0, '0},
            '{8'hFF,     1'b0, 1'b1, data_beat(8'hFF)},
            '{8'h01,     1'b0, 1'b1, data_beat(8'h01)},
            '{CH_BSLASH, 1'b0, 1'b0, '0},
            '{CH_LC_N,   1'b0, 1'b1, data_beat(CH_LF)},
            '{CH_BSLASH, 1'b0, 1'b0, '0},
            '{CH_LC_U,   1'b0, 1'b0, '0},
            '{8'h30,     1'b0, 1'b0, '0},
            '{8'h30,     1'b0, 1'b0, '0},
            '{8'h30,     1'b0, 1'b0, '0},
            '{8'h30,     1'b0, 1'b1, data_beat(8'h00)},
            '{CH_BSLASH, 1'b0, 1'b0, '0},
            '{CH_LC_U,   1'b0, 1'b0, '0},
            '{8'h46,     1'b0, 1'b0, '0},
            '{CH_LC_F,   1'b0, 1'b0, '0},
            '{8'h46,     1'b0, 1'b0, '0},
            '{CH_LC_F,   1'b0, 1'b0, '0},
            '{CH_QUOTE,  1'b0, 1'b0, '0},
            '{CH_SPACE,  1'b1, 1'b1, status_beat(ST_OK)},
            // missing opening quote, then discard through end of text
            '{8'h41,     1'b0, 1'b1, status_beat(ST_NOOPEN)},
            '{CH_QUOTE,  1'b0, 1'b0, '0},
            '{8'h00,     1'b1, 1'b0, '0},
            // zero byte inside the body without end of text
            '{CH_QUOTE,  1'b0, 1'b0, '0},
            '{8'h00,     1'b0, 1'b1, status_beat(ST_NOCLOSE)},
            '{8'h80,     1'b1, 1'b0, '0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (directed_rows[i])
            send_beat(directed_rows[i].text_byte, directed_rows[i].end_of_text,
                      directed_rows[i].typed, directed_rows[i].want);

        // random texts, idle stretches early, none at the end
        while (live_beats < LIVE_TARGET) begin
            idle_en = (live_beats < LIVE_TARGET - 70) && ($urandom_range(0, 3) != 0);
            send_random_text();
        end
        idle_en  = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then a few more cycles for stray beats
        while (decoded_expect.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
